// File: src/sbrra_pkg.sv
`timescale 1ns / 1ps

package sbrra_pkg;

    // Fixed field widths of the bus words
    localparam int AW      = 20;
    localparam int DATA_W  = 32;
    localparam int OWNER_W = 3;
    localparam int CMD_W   = 2;
    localparam int OP_W    = 2;
    localparam int DLY_W   = 4;

    // Operation codes of an input word
    localparam logic [OP_W-1:0] OP_POST   = 2'd0;
    localparam logic [OP_W-1:0] OP_SHARED = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // Bus command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RDX   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [OWNER_W-1:0] requester;
        logic [CMD_W-1:0]   command;
        logic [AW-1:0]      address;
        logic [DATA_W-1:0]  write_data;
    } in_word_t;

    typedef struct packed {
        logic [OWNER_W-1:0] bus_owner;
        logic [CMD_W-1:0]   bus_command;
        logic [AW-1:0]      bus_address;
        logic [DATA_W-1:0]  bus_word;
        logic               shared_line;
        logic               block_busy;
        logic               fresh_transaction;
    } out_word_t;

endpackage

// File: src/snoop_bus_round_robin_arbiter_core.sv
`timescale 1ns / 1ps

// Snooping bus arbiter with flush priority and round-robin read grants.
// Input channel (in_valid / in_stall / in_word): each word posts a request
// into a requester slot, raises the shared line, or is one bus clock tick.
// Output channel (out_valid / out_stall / out_word): exactly one word per
// input word, carrying the bus lines after that input took effect.
// Configuration: cfg_write loads cfg_data into the grant delay register
// (ticks from a round-robin grant until its command drives the bus).
// Flow: an accepted input word is held in the input register, evaluated from
// there, and its result is loaded into the output register. Throughput: one
// word per cycle while out_stall does not hold a waiting result, set by the
// single evaluation pass between the input register and the output register.
// Stall: while out_stall holds a waiting result, the output register holds,
// one more word is taken into the input register if it is empty, then in_stall rises.
// Reset: all slots empty, bus lines idle with no command, no block transfer
// in progress, grant delay 1, round robin starts at core 0.
module snoop_bus_round_robin_arbiter_core #(
    parameter int WORDS_PER_BLOCK = 4,
    parameter int ADDR_BITS       = 20,
    parameter int NUM_CORES       = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sbrra_pkg::in_word_t               in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sbrra_pkg::out_word_t              out_word,
    input  logic                              cfg_write,
    input  logic [sbrra_pkg::DLY_W-1:0]       cfg_data
);

    localparam int AW        = sbrra_pkg::AW;
    localparam int DW        = sbrra_pkg::DATA_W;
    localparam int CW        = sbrra_pkg::CMD_W;
    localparam int OW        = sbrra_pkg::OWNER_W;
    localparam int DLW       = sbrra_pkg::DLY_W;
    localparam int NUM_SLOTS = NUM_CORES + 1;
    localparam int LW        = $clog2(NUM_CORES);
    localparam int EW        = ADDR_BITS;
    localparam int XW        = (ADDR_BITS > AW) ? ADDR_BITS : AW;
    localparam int WFW       = $clog2(WORDS_PER_BLOCK + 1);
    localparam int RS        = 24;
    localparam int RW        = 25;
    localparam int PW        = AW + RW;
    localparam logic [AW-1:0]  ADDR_MASK = (ADDR_BITS >= AW) ? {AW{1'b1}} :
                                           AW'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [RW-1:0]  RECIP     = RW'((64'd1 << RS) / WORDS_PER_BLOCK);
    localparam logic [LW-1:0]  LAST_INIT = LW'(NUM_CORES - 1);

    // Handshake and pipeline registers
    logic                  in_valid_reg;
    sbrra_pkg::in_word_t   in_word_reg;
    logic                  out_valid_reg;
    sbrra_pkg::out_word_t  out_word_reg;
    logic                  proc;

    // Configuration
    logic [DLW-1:0]        grant_delay_reg;

    // Requester slots
    logic                  slot_valid_reg  [NUM_SLOTS];
    logic                  slot_valid_next [NUM_SLOTS];
    logic [CW-1:0]         slot_cmd_reg    [NUM_SLOTS];
    logic [AW-1:0]         slot_addr_reg   [NUM_SLOTS];
    logic [DW-1:0]         slot_word_reg   [NUM_SLOTS];
    logic [3:0]            slot_rem_reg    [NUM_SLOTS];

    // Bus and arbitration state
    logic [OW-1:0]  line_owner_reg, line_owner_next;
    logic [CW-1:0]  line_cmd_reg, line_cmd_next;
    logic [AW-1:0]  line_addr_reg, line_addr_next;
    logic [DW-1:0]  line_word_reg, line_word_next;
    logic           shared_reg, shared_next;
    logic           busy_reg, busy_next;
    logic           fresh_reg, fresh_next;
    logic [WFW-1:0] flushed_reg, flushed_next;
    logic [LW-1:0]  last_reg, last_next;
    logic           dly_active_reg, dly_active_next;
    logic [DLW-1:0] dly_left_reg, dly_left_next;
    logic [CW-1:0]  held_cmd_reg, held_cmd_next;
    logic [OW-1:0]  held_owner_reg, held_owner_next;
    logic [DW-1:0]  held_word_reg, held_word_next;
    logic [3:0]     held_rem_reg, held_rem_next;
    logic [EW-1:0]  expected_reg, expected_next;

    // Post path: masked address and its offset within a block
    logic [AW-1:0]  post_addr;
    logic [PW-1:0]  post_prod;
    logic [AW-1:0]  post_quo;
    logic [AW-1:0]  post_rem_wide;
    logic [4:0]     post_rem5;
    logic [3:0]     post_rem;
    logic           post_en;

    // Flush selection
    logic                  fl_hit  [NUM_SLOTS];
    logic                  fl_found;
    logic [NUM_SLOTS-1:0]  fl_sel;
    logic [OW-1:0]         fl_owner;
    logic [AW-1:0]         fl_addr;
    logic [DW-1:0]         fl_word;

    // Round-robin selection
    logic [NUM_CORES-1:0]  rr_ok;
    logic                  rr_found;
    logic [NUM_CORES-1:0]  rr_sel;
    logic [LW-1:0]         rr_idx;
    logic [LW:0]           rr_cand;
    logic [CW-1:0]         rr_cmd;
    logic [AW-1:0]         rr_addr;
    logic [DW-1:0]         rr_word;
    logic [3:0]            rr_rem;

    logic [DLW-1:0]        dly_dec;
    logic [WFW-1:0]        flushed_inc;

    // Handshake: evaluate when the output register is free or being drained
    assign proc      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Block offset of the posted address: reciprocal multiply and one correction
    assign post_en       = proc && (in_word_reg.op == sbrra_pkg::OP_POST) &&
                           (32'(in_word_reg.requester) < 32'(NUM_SLOTS));
    assign post_addr     = in_word_reg.address & ADDR_MASK;
    assign post_prod     = PW'(post_addr) * PW'(RECIP);
    assign post_quo      = post_prod[RS+AW-1:RS];
    assign post_rem_wide = post_addr - AW'(RW'(post_quo) * RW'(WORDS_PER_BLOCK));
    assign post_rem5     = post_rem_wide[4:0];
    assign post_rem      = (post_rem5 >= 5'(WORDS_PER_BLOCK)) ?
                           4'(post_rem5 - 5'(WORDS_PER_BLOCK)) : 4'(post_rem5);

    // Flush candidates: first matching slot in fixed order
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            fl_hit[i] = slot_valid_reg[i] && (slot_cmd_reg[i] == sbrra_pkg::CMD_FLUSH) &&
                        (!busy_reg || (XW'(expected_reg) == XW'(slot_addr_reg[i])));
        end
    end

    always_comb
    begin
        fl_found = 1'b0;
        fl_sel   = '0;
        fl_owner = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!fl_found && fl_hit[i])
            begin
                fl_found  = 1'b1;
                fl_sel[i] = 1'b1;
                fl_owner  = OW'(i);
            end
        end
    end

    always_comb
    begin
        fl_addr = '0;
        fl_word = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (fl_sel[i])
            begin
                fl_addr = fl_addr | slot_addr_reg[i];
                fl_word = fl_word | slot_word_reg[i];
            end
        end
    end

    // Round-robin candidates among the cores, starting after the last winner
    always_comb
    begin
        for (int c = 0; c < NUM_CORES; c++)
        begin
            rr_ok[c] = slot_valid_reg[c] && (slot_cmd_reg[c] != sbrra_pkg::CMD_FLUSH);
        end
    end

    always_comb
    begin
        rr_found = 1'b0;
        rr_sel   = '0;
        rr_idx   = '0;
        rr_cand  = '0;
        for (int k = 1; k <= NUM_CORES; k++)
        begin
            rr_cand = (LW+1)'(last_reg) + (LW+1)'(k);
            if (rr_cand >= (LW+1)'(NUM_CORES))
            begin
                rr_cand = rr_cand - (LW+1)'(NUM_CORES);
            end
            if (!rr_found && rr_ok[LW'(rr_cand)])
            begin
                rr_found             = 1'b1;
                rr_sel[LW'(rr_cand)] = 1'b1;
                rr_idx               = LW'(rr_cand);
            end
        end
    end

    always_comb
    begin
        rr_cmd  = '0;
        rr_addr = '0;
        rr_word = '0;
        rr_rem  = '0;
        for (int c = 0; c < NUM_CORES; c++)
        begin
            if (rr_sel[c])
            begin
                rr_cmd  = rr_cmd  | slot_cmd_reg[c];
                rr_addr = rr_addr | slot_addr_reg[c];
                rr_word = rr_word | slot_word_reg[c];
                rr_rem  = rr_rem  | slot_rem_reg[c];
            end
        end
    end

    assign dly_dec     = dly_left_reg - DLW'(1);
    assign flushed_inc = flushed_reg + WFW'(1);

    // Next state of the bus and arbitration for the word in the input register
    always_comb
    begin
        line_owner_next = line_owner_reg;
        line_cmd_next   = line_cmd_reg;
        line_addr_next  = line_addr_reg;
        line_word_next  = line_word_reg;
        shared_next     = shared_reg;
        busy_next       = busy_reg;
        fresh_next      = fresh_reg;
        flushed_next    = flushed_reg;
        last_next       = last_reg;
        dly_active_next = dly_active_reg;
        dly_left_next   = dly_left_reg;
        held_cmd_next   = held_cmd_reg;
        held_owner_next = held_owner_reg;
        held_word_next  = held_word_reg;
        held_rem_next   = held_rem_reg;
        expected_next   = expected_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_valid_next[i] = slot_valid_reg[i];
        end

        if (proc)
        begin
            case (in_word_reg.op)
                sbrra_pkg::OP_POST:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (post_en && (32'(in_word_reg.requester) == 32'(i)))
                        begin
                            slot_valid_next[i] = 1'b1;
                        end
                    end
                end
                sbrra_pkg::OP_SHARED:
                begin
                    shared_next = 1'b1;
                end
                sbrra_pkg::OP_TICK:
                begin
                    if (dly_active_reg)
                    begin
                        // Count down a pending grant; drive the bus when it expires
                        dly_left_next = dly_dec;
                        if (dly_dec == '0)
                        begin
                            dly_active_next = 1'b0;
                            line_cmd_next   = held_cmd_reg;
                            line_owner_next = held_owner_reg;
                            line_addr_next  = AW'(expected_reg);
                            expected_next   = expected_reg - EW'(held_rem_reg);
                            line_word_next  = held_word_reg;
                            busy_next       = 1'b1;
                            flushed_next    = '0;
                            fresh_next      = 1'b1;
                        end
                    end
                    else if (fl_found)
                    begin
                        // Drive the flush and advance the expected address
                        expected_next   = expected_reg + EW'(1);
                        line_owner_next = fl_owner;
                        line_cmd_next   = sbrra_pkg::CMD_FLUSH;
                        line_addr_next  = fl_addr;
                        line_word_next  = fl_word;
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (fl_sel[i])
                            begin
                                slot_valid_next[i] = 1'b0;
                            end
                        end
                        if (busy_reg)
                        begin
                            if (32'(flushed_inc) >= 32'(WORDS_PER_BLOCK))
                            begin
                                busy_next    = 1'b0;
                                shared_next  = 1'b0;
                                flushed_next = '0;
                            end
                            else
                            begin
                                flushed_next = flushed_inc;
                            end
                        end
                        fresh_next = 1'b1;
                    end
                    else if (busy_reg)
                    begin
                        // Blocked: wait for the expected flush
                    end
                    else if (rr_found)
                    begin
                        // Grant a core and start the delay
                        dly_active_next = 1'b1;
                        dly_left_next   = (grant_delay_reg == '0) ? DLW'(1) : grant_delay_reg;
                        held_cmd_next   = rr_cmd;
                        held_owner_next = OW'(rr_idx);
                        expected_next   = EW'(rr_addr);
                        held_word_next  = rr_word;
                        held_rem_next   = rr_rem;
                        last_next       = rr_idx;
                        for (int c = 0; c < NUM_CORES; c++)
                        begin
                            if (rr_sel[c])
                            begin
                                slot_valid_next[c] = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        line_cmd_next = sbrra_pkg::CMD_NONE;
                        fresh_next    = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_word_reg <= in_word;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_delay_reg <= DLW'(1);
        end
        else if (cfg_write)
        begin
            grant_delay_reg <= cfg_data;
        end
    end

    // Slot payload: write on a post
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (post_en && (32'(in_word_reg.requester) == 32'(i)))
            begin
                slot_cmd_reg[i]  <= in_word_reg.command;
                slot_addr_reg[i] <= post_addr;
                slot_word_reg[i] <= in_word_reg.write_data;
                slot_rem_reg[i]  <= post_rem;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
            line_owner_reg <= '0;
            line_cmd_reg   <= sbrra_pkg::CMD_NONE;
            line_addr_reg  <= '0;
            line_word_reg  <= '0;
            shared_reg     <= 1'b0;
            busy_reg       <= 1'b0;
            fresh_reg      <= 1'b0;
            flushed_reg    <= '0;
            last_reg       <= LAST_INIT;
            dly_active_reg <= 1'b0;
            dly_left_reg   <= '0;
            held_cmd_reg   <= sbrra_pkg::CMD_NONE;
            held_owner_reg <= '0;
            held_word_reg  <= '0;
            held_rem_reg   <= '0;
            expected_reg   <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_valid_reg[i] <= slot_valid_next[i];
            end
            line_owner_reg <= line_owner_next;
            line_cmd_reg   <= line_cmd_next;
            line_addr_reg  <= line_addr_next;
            line_word_reg  <= line_word_next;
            shared_reg     <= shared_next;
            busy_reg       <= busy_next;
            fresh_reg      <= fresh_next;
            flushed_reg    <= flushed_next;
            last_reg       <= last_next;
            dly_active_reg <= dly_active_next;
            dly_left_reg   <= dly_left_next;
            held_cmd_reg   <= held_cmd_next;
            held_owner_reg <= held_owner_next;
            held_word_reg  <= held_word_next;
            held_rem_reg   <= held_rem_next;
            expected_reg   <= expected_next;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else if (proc)
        begin
            out_valid_reg                  <= 1'b1;
            out_word_reg.bus_owner         <= line_owner_next;
            out_word_reg.bus_command       <= line_cmd_next;
            out_word_reg.bus_address       <= line_addr_next;
            out_word_reg.bus_word          <= line_word_next;
            out_word_reg.shared_line       <= shared_next;
            out_word_reg.block_busy        <= busy_next;
            out_word_reg.fresh_transaction <= fresh_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// File: src/sbrra_checker.sv
`timescale 1ns / 1ps

module sbrra_checker #(
    parameter int NUM_CORES = 4
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input sbrra_pkg::out_word_t out_word
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    // An idle bus shows no command
    a_idle_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.fresh_transaction |->
            out_word.bus_command == sbrra_pkg::CMD_NONE)
        else $error("command on bus without a transaction");

    // Only cores and memory own the bus
    a_owner_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 4'(out_word.bus_owner) <= 4'(NUM_CORES))
        else $error("bus owner out of range");

    // A block ends on a flush and drops the shared line
    a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $fell(out_word.block_busy) |->
            !out_word.shared_line && out_word.bus_command == sbrra_pkg::CMD_FLUSH)
        else $error("block ended without a flush or with shared raised");

endmodule

bind snoop_bus_round_robin_arbiter_core sbrra_checker #(
    .NUM_CORES(NUM_CORES)
) u_sbrra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
